### hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies the consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### hdl/idll_pkg.sv
// Package for the indexed doubly linked list: codes, states and the node index table.
package idll_pkg;

    // Width of the node and link fields on the stream ports
    localparam int unsigned FIELD_W            = 8;
    localparam int unsigned FIELD_SPAN         = 2 ** FIELD_W;
    localparam int unsigned NODE_COUNT_DEFAULT = 256;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_ANCHOR_OUT = 2'd1,
        STATUS_TARGET_IN  = 2'd2,
        STATUS_TARGET_OUT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_WRITE2,
        S_DELIVER
    } state_t;

    // Maps every field value to its node index (value modulo the node count)
    typedef logic [FIELD_SPAN-1:0][FIELD_W-1:0] node_tbl_t;

    // Built by a wrapping counter, evaluated at elaboration
    function automatic node_tbl_t build_node_tbl(int unsigned node_count);
        node_tbl_t            tbl;
        logic [FIELD_W-1:0]   r;
        r = '0;
        for (int i = 0; i < FIELD_SPAN; i++)
        begin
            tbl[i] = r;
            if ({{(32-FIELD_W){1'b0}}, r} + 32'd1 >= node_count)
            begin
                r = '0;
            end
            else
            begin
                r = r + 1'b1;
            end
        end
        return tbl;
    endfunction

endpackage

### hdl/idll_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module idll_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### hdl/idll_seq.sv
// Sequencer: clearing pass, membership checks, link updates and the result register.
module idll_seq #(
    parameter int unsigned NODE_COUNT = idll_pkg::NODE_COUNT_DEFAULT,
    localparam int unsigned IDX_W = $clog2(NODE_COUNT)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request side
    input  logic                         in_valid,
    output logic                         in_ready,
    input  idll_pkg::op_t                in_op,
    input  logic [IDX_W-1:0]             in_anchor,
    input  logic [IDX_W-1:0]             in_target,
    // result side
    output logic                         out_valid,
    input  logic                         out_ready,
    output idll_pkg::status_t            out_status,
    output logic [idll_pkg::FIELD_W-1:0] out_succ,
    output logic [idll_pkg::FIELD_W-1:0] out_pred,
    // member/successor memory: {member, successor}
    output logic                         sm_we,
    output logic [IDX_W-1:0]             sm_waddr,
    output logic [IDX_W:0]               sm_wdata,
    input  logic [IDX_W:0]               sm_a_rdata,
    input  logic [IDX_W:0]               sm_t_rdata,
    // predecessor memory
    output logic                         pr_we,
    output logic [IDX_W-1:0]             pr_waddr,
    output logic [IDX_W-1:0]             pr_wdata,
    input  logic [IDX_W-1:0]             pr_t_rdata
);

    import idll_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

    state_t            state_reg,    state_next;
    logic [IDX_W-1:0]  clr_cnt_reg,  clr_cnt_next;
    op_t               op_reg,       op_next;
    logic [IDX_W-1:0]  anchor_reg,   anchor_next;
    logic [IDX_W-1:0]  target_reg,   target_next;
    logic [IDX_W-1:0]  after_reg,    after_next;
    status_t           status_reg,   status_next;
    logic [IDX_W-1:0]  res_succ_reg, res_succ_next;
    logic [IDX_W-1:0]  res_pred_reg, res_pred_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [FIELD_W-1:0] out_succ_reg;
    logic [FIELD_W-1:0] out_pred_reg;

    logic              out_load;
    logic              slot_free;
    logic              mem_a, mem_t;
    logic [IDX_W-1:0]  succ_a, succ_t;
    status_t           lookup_status;

    // Read data fields, valid in the lookup state
    assign mem_a  = sm_a_rdata[IDX_W];
    assign succ_a = sm_a_rdata[IDX_W-1:0];
    assign mem_t  = sm_t_rdata[IDX_W];
    assign succ_t = sm_t_rdata[IDX_W-1:0];

    assign slot_free = !out_valid_reg || out_ready;

    // Membership checks; anchor check wins over target check on insert
    always_comb
    begin
        priority if (op_reg == OP_REMOVE)
        begin
            lookup_status = mem_t ? STATUS_DONE : STATUS_TARGET_OUT;
        end
        else if (!mem_a)
        begin
            lookup_status = STATUS_ANCHOR_OUT;
        end
        else if (mem_t)
        begin
            lookup_status = STATUS_TARGET_IN;
        end
        else
        begin
            lookup_status = STATUS_DONE;
        end
    end

    // Next state, memory writes and handshakes
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        anchor_next    = anchor_reg;
        target_next    = target_reg;
        after_next     = after_reg;
        status_next    = status_reg;
        res_succ_next  = res_succ_reg;
        res_pred_next  = res_pred_reg;
        in_ready       = 1'b0;
        out_load       = 1'b0;
        sm_we          = 1'b0;
        sm_waddr       = target_reg;
        sm_wdata       = '0;
        pr_we          = 1'b0;
        pr_waddr       = target_reg;
        pr_wdata       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // node 0 alone is a member, every link zero
                sm_we    = 1'b1;
                sm_waddr = clr_cnt_reg;
                sm_wdata = {clr_cnt_reg == '0, {IDX_W{1'b0}}};
                pr_we    = 1'b1;
                pr_waddr = clr_cnt_reg;
                pr_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = in_op;
                    anchor_next = in_anchor;
                    target_next = in_target;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                status_next   = lookup_status;
                res_succ_next = succ_t;
                res_pred_next = pr_t_rdata;
                if (lookup_status == STATUS_DONE && op_reg == OP_INSERT)
                begin
                    // anchor -> target, pred of old successor -> target
                    sm_we         = 1'b1;
                    sm_waddr      = anchor_reg;
                    sm_wdata      = {1'b1, target_reg};
                    pr_we         = 1'b1;
                    pr_waddr      = succ_a;
                    pr_wdata      = target_reg;
                    after_next    = succ_a;
                    res_succ_next = succ_a;
                    res_pred_next = anchor_reg;
                    state_next    = S_WRITE2;
                end
                else if (lookup_status == STATUS_DONE)
                begin
                    // bridge predecessor and successor; the predecessor is the
                    // target itself only when it is the last member
                    sm_we      = 1'b1;
                    sm_waddr   = pr_t_rdata;
                    sm_wdata   = {pr_t_rdata != target_reg, succ_t};
                    pr_we      = 1'b1;
                    pr_waddr   = succ_t;
                    pr_wdata   = pr_t_rdata;
                    after_next = succ_t;
                    state_next = S_WRITE2;
                end
                else
                begin
                    state_next = S_DELIVER;
                end
            end
            S_WRITE2:
            begin
                // target's own entry: member flag follows the operation
                sm_we    = 1'b1;
                sm_waddr = target_reg;
                sm_wdata = {op_reg == OP_INSERT, after_reg};
                pr_we    = (op_reg == OP_INSERT);
                pr_waddr = target_reg;
                pr_wdata = anchor_reg;
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        op_next     = in_op;
                        anchor_next = in_anchor;
                        target_next = in_target;
                        state_next  = S_LOOKUP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        anchor_reg   <= anchor_next;
        target_reg   <= target_next;
        after_reg    <= after_next;
        status_reg   <= status_next;
        res_succ_reg <= res_succ_next;
        res_pred_reg <= res_pred_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_succ_reg   <= FIELD_W'(res_succ_reg);
            out_pred_reg   <= FIELD_W'(res_pred_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_succ   = out_succ_reg;
    assign out_pred   = out_pred_reg;

endmodule

### hdl/indexed_doubly_linked_list.sv
// Top level of the indexed doubly linked list: index mapping, link memories, sequencer.
//
//  Channel   Dir  Handshake                    Contents (lowest bits first)
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: operation; tdata: anchor_node, target_node
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: target_next, target_prev
//
//  One operation at a time: a failed operation passes the lookup and deliver states, a
//  successful insert or remove the lookup, second write and deliver states, as its two
//  link writes share the memories' single write port. After reset a clearing pass writes
//  every node with s_axis_tready low. A result waits in the output register while the
//  next request is taken; requests stall mid-operation and while its result is blocked.
module indexed_doubly_linked_list #(
    parameter int unsigned NODE_COUNT = idll_pkg::NODE_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] anchor_node, [15:8] target_node
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] target_next, [15:8] target_prev
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    import idll_pkg::*;

    localparam int unsigned IDX_W    = $clog2(NODE_COUNT);
    localparam node_tbl_t   NODE_TBL = build_node_tbl(NODE_COUNT);

    logic [IDX_W-1:0]   anchor_idx;
    logic [IDX_W-1:0]   target_idx;
    op_t                op;
    status_t            status;
    logic [FIELD_W-1:0] succ_byte;
    logic [FIELD_W-1:0] pred_byte;

    logic               sm_we;
    logic [IDX_W-1:0]   sm_waddr;
    logic [IDX_W:0]     sm_wdata;
    logic [IDX_W:0]     sm_a_rdata;
    logic [IDX_W:0]     sm_t_rdata;
    logic               pr_we;
    logic [IDX_W-1:0]   pr_waddr;
    logic [IDX_W-1:0]   pr_wdata;
    logic [IDX_W-1:0]   pr_t_rdata;

    // Node indices, reduced modulo the node count
    assign anchor_idx = IDX_W'(NODE_TBL[s_axis_tdata[FIELD_W-1:0]]);
    assign target_idx = IDX_W'(NODE_TBL[s_axis_tdata[2*FIELD_W-1:FIELD_W]]);
    assign op         = op_t'(s_axis_tuser);

    // Member/successor memory, one copy per read address
    idll_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (NODE_COUNT)
    ) u_sm_anchor (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .raddr (anchor_idx),
        .rdata (sm_a_rdata)
    );

    idll_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (NODE_COUNT)
    ) u_sm_target (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .raddr (target_idx),
        .rdata (sm_t_rdata)
    );

    // Predecessor memory
    idll_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODE_COUNT)
    ) u_pred (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (target_idx),
        .rdata (pr_t_rdata)
    );

    idll_seq #(
        .NODE_COUNT (NODE_COUNT)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (op),
        .in_anchor  (anchor_idx),
        .in_target  (target_idx),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_succ   (succ_byte),
        .out_pred   (pred_byte),
        .sm_we      (sm_we),
        .sm_waddr   (sm_waddr),
        .sm_wdata   (sm_wdata),
        .sm_a_rdata (sm_a_rdata),
        .sm_t_rdata (sm_t_rdata),
        .pr_we      (pr_we),
        .pr_waddr   (pr_waddr),
        .pr_wdata   (pr_wdata),
        .pr_t_rdata (pr_t_rdata)
    );

    // Result packing
    assign m_axis_tdata = {pred_byte, succ_byte};
    assign m_axis_tuser = status;

endmodule

### hdl/idll_checker.sv
// Port-level checker for the indexed doubly linked list, bound to the top level.
`include "assert_macros.svh"

module idll_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // A stalled result holds
    `ASSERT_NEXT(a_result_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // Only one operation in flight: no transfer right after a transfer
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_fire, !s_axis_tready, "request taken during lookup")

    // A fresh result is preceded by a matching request transfer
    `ASSERT_CLK(a_result_latency, clk, rst_n, $rose(m_axis_tvalid) |-> $past(s_fire, 3) || $past(s_fire, 4), "result without matching request")

endmodule

bind indexed_doubly_linked_list idll_checker u_idll_checker (.*);
